[sv/alu16_with_status_flags_macros.svh]
// Assertion macros for the alu16_with_status_flags block.
// Taken in by the top level; no other dependencies.
`ifndef ALU16_WITH_STATUS_FLAGS_MACROS_SVH
`define ALU16_WITH_STATUS_FLAGS_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ALU16_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alu16 assertion failed");
// next-cycle implication
`define ALU16_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alu16 assertion failed");
`else
`define ALU16_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ALU16_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/alu16_pkg.sv]
// Shared constants and types of the 16-bit ALU.
// No dependencies; used by the interfaces and all modules.
package alu16_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int OP_W       = 3;

  localparam logic [OP_W-1:0] OP_AND = 3'd0;
  localparam logic [OP_W-1:0] OP_OR  = 3'd1;
  localparam logic [OP_W-1:0] OP_XOR = 3'd2;
  localparam logic [OP_W-1:0] OP_ROR = 3'd3;
  localparam logic [OP_W-1:0] OP_ROL = 3'd4;
  localparam logic [OP_W-1:0] OP_ADD = 3'd5;
  localparam logic [OP_W-1:0] OP_MUL = 3'd6;
  localparam logic [OP_W-1:0] OP_DIV = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic exec;      // logic, rotate, add, mul and divide-by-zero results; divider setup
    logic div_step;  // one quotient bit
    logic div_fix;   // apply quotient sign
    logic write;     // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_run;   // divide with nonzero divisor
  } status_t;

  // result word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    logic                         zero_flag;
    logic                         carry_flag;
    logic                         negative_flag;
    logic                         underflow_flag;
    logic                         overflow_flag;
    logic                         divide_by_zero;
  } rsp_t;

endpackage

[sv/alu16_req_if.sv]
// Request channel: op code and two operands, valid/ready handshake.
// Depends on alu16_pkg.
interface alu16_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [alu16_pkg::OP_W-1:0]             op;
  logic signed [alu16_pkg::DATA_WIDTH-1:0] operand_a;
  logic signed [alu16_pkg::DATA_WIDTH-1:0] operand_b;

  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

[sv/alu16_rsp_if.sv]
// Response channel: result and status flags, valid/ready handshake.
// Depends on alu16_pkg.
interface alu16_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [alu16_pkg::DATA_WIDTH-1:0] result;
  logic                                   zero_flag;
  logic                                   carry_flag;
  logic                                   negative_flag;
  logic                                   underflow_flag;
  logic                                   overflow_flag;
  logic                                   divide_by_zero;

  modport source (output valid, result, zero_flag, carry_flag, negative_flag,
                  underflow_flag, overflow_flag, divide_by_zero, input ready);
  modport sink   (input valid, result, zero_flag, carry_flag, negative_flag,
                  underflow_flag, overflow_flag, divide_by_zero, output ready);
endinterface

[sv/alu16_ctrl.sv]
// Sequencing FSM of the ALU: handshakes, divide step counter, output valid.
// Depends on alu16_pkg.
module alu16_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  alu16_pkg::status_t status,
  output alu16_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(alu16_pkg::DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(alu16_pkg::DATA_WIDTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DFIX  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.div_run ? S_DIV : S_WRITE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) state_next = S_DFIX;
      end
      S_DFIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + CNT_W'(1);
      if (cmd.write) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[sv/alu16_dp.sv]
// Datapath of the ALU: operand registers, logic/add/mul unit, restoring
// divider, held accumulator and output register. Depends on alu16_pkg.
module alu16_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  alu16_pkg::cmd_t                         cmd,
  output alu16_pkg::status_t                      status,
  input  logic [alu16_pkg::OP_W-1:0]              op,
  input  logic signed [alu16_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic signed [alu16_pkg::DATA_WIDTH-1:0] operand_b,
  output alu16_pkg::rsp_t                         rsp
);

  localparam int DW = alu16_pkg::DATA_WIDTH;

  logic [alu16_pkg::OP_W-1:0] op_r;
  logic signed [DW-1:0]       a_r, b_r;
  logic [DW-1:0]              acc;
  alu16_pkg::rsp_t            res_r, exec_rsp, fix_rsp;

  // divider state
  logic [DW-1:0] rem, quo, dvs;
  logic          qneg;
  logic [DW:0]   trial;
  logic [DW-1:0] mag_a, mag_b, quo_signed;

  logic [DW:0]          sum_ext;
  logic signed [2*DW-1:0] prod;

  assign status.div_run = (op_r == alu16_pkg::OP_DIV) && (b_r != '0);

  assign mag_a = a_r[DW-1] ? (DW'(~a_r) + DW'(1)) : DW'(a_r);
  assign mag_b = b_r[DW-1] ? (DW'(~b_r) + DW'(1)) : DW'(b_r);
  assign trial = {rem, quo[DW-1]} - {1'b0, dvs};
  assign quo_signed = qneg ? (~quo + DW'(1)) : quo;

  assign sum_ext = {1'b0, a_r} + {1'b0, b_r};
  assign prod    = a_r * b_r;

  always_comb begin
    exec_rsp = '0;
    case (op_r)
      alu16_pkg::OP_AND: exec_rsp.result = a_r & b_r;
      alu16_pkg::OP_OR:  exec_rsp.result = a_r | b_r;
      alu16_pkg::OP_XOR: exec_rsp.result = a_r ^ b_r;
      alu16_pkg::OP_ROR: begin
        exec_rsp.result     = {a_r[0], a_r[DW-1:1]};
        exec_rsp.carry_flag = a_r[0];
      end
      alu16_pkg::OP_ROL: begin
        exec_rsp.result     = {a_r[DW-2:0], a_r[DW-1]};
        exec_rsp.carry_flag = a_r[DW-1];
      end
      alu16_pkg::OP_ADD: begin
        exec_rsp.result         = sum_ext[DW-1:0];
        exec_rsp.carry_flag     = sum_ext[DW];
        exec_rsp.overflow_flag  = !a_r[DW-1] && !b_r[DW-1] && sum_ext[DW-1];
        exec_rsp.underflow_flag = a_r[DW-1] && b_r[DW-1] && !sum_ext[DW-1];
      end
      alu16_pkg::OP_MUL: begin
        // out of range when the upper bits are not a sign extension
        exec_rsp.result         = prod[DW-1:0];
        exec_rsp.overflow_flag  = !prod[2*DW-1] && (|prod[2*DW-2:DW-1]);
        exec_rsp.underflow_flag = prod[2*DW-1] && !(&prod[2*DW-2:DW-1]);
        exec_rsp.carry_flag     = exec_rsp.overflow_flag || exec_rsp.underflow_flag;
      end
      default: begin
        // divide by zero; nonzero divisor goes through the divider
        exec_rsp.result         = acc;
        exec_rsp.divide_by_zero = 1'b1;
      end
    endcase
    exec_rsp.zero_flag     = (exec_rsp.result == '0);
    exec_rsp.negative_flag = exec_rsp.result[DW-1];
  end

  // quotient word: only zero and negative flags can be set
  always_comb begin
    fix_rsp               = '0;
    fix_rsp.result        = quo_signed;
    fix_rsp.zero_flag     = (quo_signed == '0);
    fix_rsp.negative_flag = quo_signed[DW-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      a_r  <= operand_a;
      b_r  <= operand_b;
    end
    if (cmd.exec) begin
      res_r <= exec_rsp;
      rem   <= '0;
      quo   <= mag_a;
      dvs   <= mag_b;
      qneg  <= a_r[DW-1] ^ b_r[DW-1];
    end
    if (cmd.div_step) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-2:0], quo[DW-1]};
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) res_r <= fix_rsp;
    if (cmd.write) rsp <= res_r;
  end

  // held accumulator: every result except a divide by zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.exec && !exec_rsp.divide_by_zero && !status.div_run) begin
      acc <= exec_rsp.result;
    end else if (cmd.div_fix) begin
      acc <= quo_signed;
    end
  end

endmodule

[sv/alu16_with_status_flags.sv]
// 16-bit signed ALU with status flags. One request word (op, operand_a,
// operand_b) gives one response word (result plus zero, carry, negative,
// underflow, overflow and divide_by_zero flags). Ops: and, or, xor, rotate
// right/left by one, add, multiply (low 16 bits kept) and divide truncating
// toward zero. Each result except a divide by zero is kept in a held
// accumulator (cleared by reset); a divide by zero returns that held value
// with divide_by_zero set and carry/underflow/overflow clear. Most negative
// divided by minus one wraps to most negative with no overflow flag. Items
// are taken one at a time: logic, rotate, add, multiply and divide by zero
// pass through capture, execute and write to the output register; a divide
// with nonzero divisor passes through capture, execute, the restoring divider
// that produces one quotient bit per cycle, a sign fix and the write.
// The output register lets a new request be accepted while the previous
// response still waits for rsp.ready.
// Depends on alu16_pkg, alu16_req_if, alu16_rsp_if, alu16_ctrl, alu16_dp.
`include "alu16_with_status_flags_macros.svh"

module alu16_with_status_flags (
  input logic         clk,
  input logic         rst,
  alu16_req_if.sink   req,
  alu16_rsp_if.source rsp
);

  alu16_pkg::cmd_t    cmd;
  alu16_pkg::status_t status;
  alu16_pkg::rsp_t    rsp_word;

  // FSM: owns both handshakes and the divide step count
  alu16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // all arithmetic, the accumulator and the output payload register
  alu16_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .op        (req.op),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .rsp       (rsp_word)
  );

  assign rsp.result         = rsp_word.result;
  assign rsp.zero_flag      = rsp_word.zero_flag;
  assign rsp.carry_flag     = rsp_word.carry_flag;
  assign rsp.negative_flag  = rsp_word.negative_flag;
  assign rsp.underflow_flag = rsp_word.underflow_flag;
  assign rsp.overflow_flag  = rsp_word.overflow_flag;
  assign rsp.divide_by_zero = rsp_word.divide_by_zero;

  // one word in flight: no second capture right after an accept
  `ALU16_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  // divide by zero never carries arithmetic flags
  `ALU16_ASSERT_IMPL(a_dz_clean, clk, rst, rsp.valid && rsp.divide_by_zero, !rsp.carry_flag && !rsp.underflow_flag && !rsp.overflow_flag)
  // a result cannot be both above and below range
  `ALU16_ASSERT_IMPL(a_range_excl, clk, rst, rsp.valid, !(rsp.underflow_flag && rsp.overflow_flag))
  // a step of the divider never overlaps a write of the output register
  `ALU16_ASSERT_IMPL(a_cmd_excl, clk, rst, cmd.div_step || cmd.div_fix, !cmd.write && !cmd.load)

endmodule
